/* sv/etc_pkg.sv */
// ---------------------------------------------------------------------------
// etc_pkg: eased tween channel shared definitions
// Widths, fixed-point constants, register indexes, easing and property codes.
// ---------------------------------------------------------------------------
package etc_pkg;

    localparam int TIME_BITS = 24;
    localparam int FRAC_BITS = 16;

    localparam int STEP_W    = 16;
    localparam int VAL_W     = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int MODE_W    = 3;
    localparam int PROP_W    = 4;
    localparam int DUR_CFG_W = 24;

    localparam int EL_W   = TIME_BITS + 1;
    localparam int SUM_W  = ((EL_W > STEP_W) ? EL_W : STEP_W) + 1;
    localparam int DLY_W  = (TIME_BITS < DUR_CFG_W) ? TIME_BITS : DUR_CFG_W;
    localparam int P_W    = FRAC_BITS + 1;
    localparam int OP_W   = FRAC_BITS + 3;
    localparam int R_W    = OP_W + 2;
    localparam int MAG_W  = VAL_W + 1;
    localparam int PROD_W = MAG_W + OP_W;
    localparam int CNT_W  = $clog2(FRAC_BITS + 1);

    localparam logic [SUM_W-1:0] EL_CAP = (SUM_W'(1) << EL_W) - SUM_W'(1);
    localparam logic [OP_W-1:0]  P_ONE  = OP_W'(1) << FRAC_BITS;
    localparam logic [OP_W-1:0]  P_HALF = OP_W'(1) << (FRAC_BITS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_VALUE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TICKS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION_TICKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EASE_MODE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PROPERTY = 3'd5;

    localparam logic [MODE_W-1:0] EASE_LINEAR     = 3'd0;
    localparam logic [MODE_W-1:0] EASE_IN_QUAD    = 3'd1;
    localparam logic [MODE_W-1:0] EASE_OUT_QUAD   = 3'd2;
    localparam logic [MODE_W-1:0] EASE_INOUT_QUAD = 3'd3;
    localparam logic [MODE_W-1:0] EASE_IN_CUBIC   = 3'd4;
    localparam logic [MODE_W-1:0] EASE_OUT_CUBIC  = 3'd5;
    localparam logic [MODE_W-1:0] EASE_INOUT_CUBIC = 3'd6;

    localparam logic [PROP_W-1:0] PROP_COLOR_LO = 4'd5;
    localparam logic [PROP_W-1:0] PROP_COLOR_HI = 4'd9;

    localparam logic [0:0] CMD_TICK  = 1'b0;
    localparam logic [0:0] CMD_START = 1'b1;

endpackage

/* sv/etc_intf.sv */
// ---------------------------------------------------------------------------
// etc_intf: eased tween channel stream interfaces
// Tick/start input channel and result output channel, valid/ready.
// ---------------------------------------------------------------------------
interface etc_in_if import etc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [STEP_W-1:0] time_step;

    modport source (output valid, output cmd, output time_step, input ready);
    modport sink   (input valid, input cmd, input time_step, output ready);
endinterface

interface etc_out_if import etc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [VAL_W-1:0]  eased_value;
    logic [PROP_W-1:0]        property_code;
    logic                     value_written;
    logic                     finished;

    modport source (output valid, output eased_value, output property_code,
                    output value_written, output finished, input ready);
    modport sink   (input valid, input eased_value, input property_code,
                    input value_written, input finished, output ready);
endinterface

/* sv/eased_tween_channel_top.sv */
// ---------------------------------------------------------------------------
// eased_tween_channel_top: one eased tween channel
// Elapsed-time tracking, serial progress divide, easing and interpolation
// on one shared multiplier under a small sequencer.
//
//   channel   dir  handshake     payload
//   i_tick    in   valid/ready   cmd, time_step
//   o_res     out  valid/ready   eased_value, property_code, value_written,
//                                finished
//   i_cfg_*   in   write enable  register index, write data
//
// A start transaction makes no result. A tick before the delay ends passes
// S_EVAL only; one ending a zero-duration tween goes S_EVAL, S_FIN; a moving
// tick runs S_EVAL, S_DIV (serial divider, one quotient bit a cycle), S_M1,
// S_M2 for a cubic curve, S_POST, S_LERP, S_FIN; the end point skips S_DIV.
// Reset clears the configuration registers, elapsed time and the armed flag. One item is
// in work at a time; a result waits in the output register while the next
// transaction is taken, and the sequencer holds only if a second result
// would overwrite it.
// ---------------------------------------------------------------------------
module eased_tween_channel_top
    import etc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    etc_in_if.sink               i_tick,
    etc_out_if.source            o_res
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_EVAL = 8'b0000_0010,
        S_DIV  = 8'b0000_0100,
        S_M1   = 8'b0000_1000,
        S_M2   = 8'b0001_0000,
        S_POST = 8'b0010_0000,
        S_LERP = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic signed [VAL_W-1:0] r_start_val, r_end_val;
    logic [DLY_W-1:0]        r_delay, r_dur;
    logic [MODE_W-1:0]       r_mode;
    logic [PROP_W-1:0]       r_prop;

    logic [EL_W-1:0]  r_elapsed;
    logic             r_running;
    logic [P_W-1:0]   r_p;
    logic [P_W-1:0]   r_e;
    logic [MAG_W-1:0] r_mag;
    logic             r_neg;
    logic             r_fin;
    logic             r_written;

    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_value;
    logic [PROP_W-1:0]       r_out_prop;
    logic                    r_out_written;
    logic                    r_out_fin;

    logic             in_fire;
    logic             load;
    logic [SUM_W-1:0] el_sum;
    logic [EL_W-1:0]  since;
    logic             past_delay;
    logic             at_end;
    logic             dur_zero;
    logic             div_start;
    logic             div_done;
    logic [FRAC_BITS-1:0] div_quot;

    logic [OP_W-1:0]   tx, op_x, op_y, op_z, m;
    logic              two_mul;
    logic              low_half;
    logic [R_W-1:0]    eased;
    logic [P_W-1:0]    e_clamp;
    logic [MAG_W-1:0]  mul_a;
    logic [OP_W-1:0]   mul_b;
    logic [PROD_W-1:0] prod;
    logic signed [VAL_W+1:0] diff;
    logic [MAG_W-1:0]  dmag;
    logic signed [VAL_W+1:0] val_wide;
    logic signed [VAL_W-1:0] val;
    logic signed [VAL_W-1:0] fin_val;
    logic              is_color;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_val <= '0;
            r_end_val   <= '0;
            r_delay     <= '0;
            r_dur       <= '0;
            r_mode      <= EASE_LINEAR;
            r_prop      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_VALUE:     r_start_val <= i_cfg_wdata;
                CFG_END_VALUE:       r_end_val   <= i_cfg_wdata;
                CFG_DELAY_TICKS:     r_delay     <= i_cfg_wdata[DLY_W-1:0];
                CFG_DURATION_TICKS:  r_dur       <= i_cfg_wdata[DLY_W-1:0];
                CFG_EASE_MODE:       r_mode      <= i_cfg_wdata[MODE_W-1:0];
                CFG_TARGET_PROPERTY: r_prop      <= i_cfg_wdata[PROP_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_tick.ready = (r_state == S_IDLE);
    assign in_fire      = i_tick.valid && i_tick.ready;

    assign el_sum     = SUM_W'(r_elapsed) + SUM_W'(i_tick.time_step);
    assign past_delay = r_elapsed >= EL_W'(r_delay);
    assign since      = r_elapsed - EL_W'(r_delay);
    assign at_end     = since >= EL_W'(r_dur);
    assign dur_zero   = (r_dur == '0);
    assign div_start  = (r_state == S_EVAL) && past_delay && !dur_zero && !at_end;

    etc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (since[DLY_W-1:0]),
        .i_den   (r_dur),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // easing operands
    always_comb begin
        tx       = OP_W'(r_p);
        low_half = tx < P_HALF;
        op_x     = tx;
        op_y     = tx;
        op_z     = tx;
        two_mul  = 1'b0;
        unique case (r_mode)
            EASE_OUT_QUAD: begin
                op_y = (P_ONE << 1) - tx;
            end
            EASE_INOUT_QUAD: begin
                if (!low_half) begin
                    op_x = (P_ONE << 2) - (tx << 1);
                end
            end
            EASE_IN_CUBIC: begin
                two_mul = 1'b1;
            end
            EASE_OUT_CUBIC: begin
                op_x    = P_ONE - tx;
                op_y    = P_ONE - tx;
                op_z    = P_ONE - tx;
                two_mul = 1'b1;
            end
            EASE_INOUT_CUBIC: begin
                two_mul = 1'b1;
                if (!low_half) begin
                    op_x = P_ONE - tx;
                    op_y = (P_ONE << 1) - (tx << 1);
                    op_z = (P_ONE << 1) - (tx << 1);
                end
            end
            default: ;
        endcase
    end

    assign m = prod[FRAC_BITS +: OP_W];

    // the interpolation product is held while the result waits
    always_comb begin
        unique case (r_state)
            S_M2: begin
                mul_a = MAG_W'(m);
                mul_b = op_z;
            end
            S_LERP, S_FIN: begin
                mul_a = r_mag;
                mul_b = OP_W'(r_e);
            end
            default: begin
                mul_a = MAG_W'(op_x);
                mul_b = op_y;
            end
        endcase
    end

    etc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // easing post step
    always_comb begin
        unique case (r_mode)
            EASE_IN_QUAD, EASE_OUT_QUAD, EASE_IN_CUBIC: eased = R_W'(m);
            EASE_INOUT_QUAD: begin
                if (low_half) begin
                    eased = R_W'(m) << 1;
                end else begin
                    eased = (m > P_ONE) ? R_W'(m - P_ONE) : '0;
                end
            end
            EASE_OUT_CUBIC: eased = (m > P_ONE) ? '0 : R_W'(P_ONE - m);
            EASE_INOUT_CUBIC: begin
                if (low_half) begin
                    eased = R_W'(m) << 2;
                end else begin
                    eased = (m < P_ONE) ? R_W'(P_ONE - m) : '0;
                end
            end
            default: eased = R_W'(r_p);
        endcase
        e_clamp = (eased > R_W'(P_ONE)) ? P_W'(P_ONE) : eased[P_W-1:0];
    end

    // interpolation result
    always_comb begin
        dmag     = prod[FRAC_BITS +: MAG_W];
        val_wide = r_neg ? ((VAL_W+2)'(r_start_val) - $signed({1'b0, dmag}))
                         : ((VAL_W+2)'(r_start_val) + $signed({1'b0, dmag}));
        val      = val_wide[VAL_W-1:0];
        is_color = (r_prop >= PROP_COLOR_LO) && (r_prop <= PROP_COLOR_HI);
        if (!r_written) begin
            fin_val = '0;
        end else if (is_color) begin
            if (val[VAL_W-1]) begin
                fin_val = '0;
            end else if (val[VAL_W-2:16] > 15'd255) begin
                fin_val = {8'h00, 8'hFF, 16'h0000};
            end else begin
                fin_val = {8'h00, val[23:16], 16'h0000};
            end
        end else begin
            fin_val = val;
        end
    end

    assign diff = (VAL_W+2)'(r_end_val) - (VAL_W+2)'(r_start_val);
    assign load = (r_state == S_FIN) && (!r_out_valid || o_res.ready);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && i_tick.cmd == CMD_TICK && r_running) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!past_delay) begin
                    n_state = S_IDLE;
                end else if (dur_zero) begin
                    n_state = S_FIN;
                end else if (at_end) begin
                    n_state = S_M1;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV:  if (div_done) n_state = S_M1;
            S_M1:   n_state = two_mul ? S_M2 : S_POST;
            S_M2:   n_state = S_POST;
            S_POST: n_state = S_LERP;
            S_LERP: n_state = S_FIN;
            S_FIN:  if (load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_elapsed <= '0;
            r_running <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                if (i_tick.cmd == CMD_START) begin
                    r_elapsed <= '0;
                    r_running <= 1'b1;
                end else if (r_running) begin
                    r_elapsed <= (el_sum > EL_CAP) ? EL_CAP[EL_W-1:0]
                                                   : el_sum[EL_W-1:0];
                end
            end
            if (r_state == S_EVAL && past_delay && (dur_zero || at_end)) begin
                r_running <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EVAL) begin
            r_neg     <= diff[VAL_W+1];
            r_mag     <= diff[VAL_W+1] ? MAG_W'(-diff) : MAG_W'(diff);
            r_fin     <= dur_zero || at_end;
            r_written <= !dur_zero;
            r_p       <= P_W'(P_ONE);
        end
        if (r_state == S_DIV && div_done) begin
            r_p <= {1'b0, div_quot};
        end
        if (r_state == S_POST) begin
            r_e <= e_clamp;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_value   <= fin_val;
            r_out_prop    <= r_prop;
            r_out_written <= r_written;
            r_out_fin     <= r_fin;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.eased_value   = r_out_value;
    assign o_res.property_code = r_out_prop;
    assign o_res.value_written = r_out_written;
    assign o_res.finished      = r_out_fin;

    a_run_until_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !r_fin) |-> r_running)
        else $error("unfinished result on an idle channel");

    a_nowrite_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !r_written) |-> r_fin)
        else $error("zero-duration result not marked finished");

    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

    a_ease_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LERP) |-> (OP_W'(r_e) <= P_ONE))
        else $error("eased progress above one");

endmodule

/* sv/etc_div.sv */
// ---------------------------------------------------------------------------
// etc_div: serial progress divider
// Restoring divide, one quotient bit per cycle: (num << FRAC_BITS) / den,
// for num < den.
// ---------------------------------------------------------------------------
module etc_div
    import etc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DLY_W-1:0]     i_num,
    input  logic [DLY_W-1:0]     i_den,
    output logic                 o_done,
    output logic [FRAC_BITS-1:0] o_quot
);

    logic [DLY_W-1:0]     r_rem, n_rem;
    logic [DLY_W-1:0]     r_den;
    logic [FRAC_BITS-1:0] r_quot, n_quot;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DLY_W:0]       shifted;
    logic                 take;

    always_comb begin
        shifted = {r_rem, 1'b0};
        take    = shifted >= {1'b0, r_den};
        n_rem   = take ? DLY_W'(shifted - {1'b0, r_den}) : shifted[DLY_W-1:0];
        n_quot  = {r_quot[FRAC_BITS-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(FRAC_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* sv/etc_mul.sv */
// ---------------------------------------------------------------------------
// etc_mul: shared multiplier
// Unsigned product with a registered output; one result per cycle.
// ---------------------------------------------------------------------------
module etc_mul
    import etc_pkg::*;
(
    input  logic              i_clk,
    input  logic [MAG_W-1:0]  i_a,
    input  logic [OP_W-1:0]   i_b,
    output logic [PROD_W-1:0] o_prod
);

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule
